// ----- rtl/ert_pkg.sv -----
package ert_pkg;

  // field widths
  localparam int EPOCH_W      = 64;
  localparam int FUNC_W       = 2;
  localparam int CPU_W        = 4;
  localparam int CORE_CNT_W   = 5;
  localparam int THRESH_W     = 8;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_ADDR_W   = 1;
  // wide enough for core_count and for any processor count up to 64
  localparam int CNT_CMP_W    = 7;

  // defaults
  localparam int MAX_CPUS_DEFAULT = 16;
  localparam logic [CORE_CNT_W-1:0] CORE_CNT_RESET = 5'd16;
  localparam logic [THRESH_W-1:0]   THRESH_RESET   = 8'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CORE_COUNT      = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EPOCH_THRESHOLD = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ENTER   = 2'd0,
    FUNC_EXIT    = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_SCAN = 2'd2
  } state_t;

  // control from the sequencer to the epoch store
  typedef struct packed {
    logic epoch_wr;
    logic flag_wr;
    logic flag_val;
    logic rd_en;
  } store_ctl_t;

endpackage

// ----- rtl/ert_sub_unit.sv -----
module ert_sub_unit (
  input  logic [ert_pkg::EPOCH_W-1:0] op_a,
  input  logic [ert_pkg::EPOCH_W-1:0] op_b,
  output logic [ert_pkg::EPOCH_W-1:0] diff,
  output logic                        borrow
);

  logic [ert_pkg::EPOCH_W:0] full;

  // shared subtractor: a - b with borrow out
  assign full   = {1'b0, op_a} - {1'b0, op_b};
  assign diff   = full[ert_pkg::EPOCH_W-1:0];
  assign borrow = full[ert_pkg::EPOCH_W];

endmodule

// ----- rtl/ert_epoch_store.sv -----
module ert_epoch_store #(
  parameter int MAX_CPUS = ert_pkg::MAX_CPUS_DEFAULT,
  parameter int AW       = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ert_pkg::store_ctl_t         ctl,
  input  logic [AW-1:0]               wr_addr,
  input  logic [ert_pkg::EPOCH_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [ert_pkg::EPOCH_W-1:0] rd_epoch,
  output logic                        rd_active
);

  logic [ert_pkg::EPOCH_W-1:0] epoch_mem_r [MAX_CPUS];
  logic [MAX_CPUS-1:0]         active_r;
  logic [ert_pkg::EPOCH_W-1:0] rd_epoch_r;
  logic                        rd_active_r;

  // local epoch memory, registered read
  always_ff @(posedge clk) begin
    if (ctl.epoch_wr) begin
      epoch_mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_epoch_r  <= epoch_mem_r[rd_addr];
      rd_active_r <= active_r[rd_addr];
    end
  end

  // in-critical flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (ctl.flag_wr) begin
      active_r[wr_addr] <= ctl.flag_val;
    end
  end

  assign rd_epoch  = rd_epoch_r;
  assign rd_active = rd_active_r;

endmodule

// ----- rtl/epoch_reclaim_tracker.sv -----
// channel   | ports                                             | handshake
// ----------+---------------------------------------------------+----------------------
// input     | in_func, in_cpu_index, in_death_epoch             | start && !busy
// result    | out_safe_to_reclaim, out_epoch_value, out_rejected| out_valid, one cycle
// config    | cfg_addr, cfg_wdata                               | cfg_we
//
// enter, exit, advance: the beat is registered, handled in EXEC, then the result strobe
// is registered. query: likewise if the age check fails or the processor count is zero,
// else a scan of up to min(processor count, MAX_CPUS) entries, one memory read per scan
// cycle while entries remain. busy is high from the cycle after the accepted beat; the
// strobe cycle takes a new beat. synchronous reset clears the epoch counter and flags and
// resets the config registers to defaults. results cannot be stalled by the receiver
module epoch_reclaim_tracker #(
  parameter int MAX_CPUS = ert_pkg::MAX_CPUS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [ert_pkg::FUNC_W-1:0]     in_func,
  input  logic [ert_pkg::CPU_W-1:0]      in_cpu_index,
  input  logic [ert_pkg::EPOCH_W-1:0]    in_death_epoch,
  output logic                           out_valid,
  output logic                           out_safe_to_reclaim,
  output logic [ert_pkg::EPOCH_W-1:0]    out_epoch_value,
  output logic                           out_rejected,
  input  logic                           cfg_we,
  input  logic [ert_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ert_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int CW = $clog2(MAX_CPUS + 1);

  ert_pkg::state_t                 state_r, state_nxt;
  ert_pkg::func_t                  func_r, func_nxt;
  logic [ert_pkg::CPU_W-1:0]       cpu_r, cpu_nxt;
  logic [ert_pkg::EPOCH_W-1:0]     death_r, death_nxt;
  logic [ert_pkg::EPOCH_W-1:0]     global_r, global_nxt;
  logic [CW-1:0]                   issue_r, issue_nxt;
  logic                            pend_r, pend_nxt;
  logic [ert_pkg::CORE_CNT_W-1:0]  ncores_r;
  logic [ert_pkg::THRESH_W-1:0]    thresh_r;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_safe_r, out_safe_nxt;
  logic [ert_pkg::EPOCH_W-1:0]     out_epoch_r, out_epoch_nxt;
  logic                            out_rej_r, out_rej_nxt;

  logic [ert_pkg::EPOCH_W-1:0]     sub_a, sub_b, sub_diff;
  logic                            sub_borrow;
  ert_pkg::store_ctl_t             st_ctl;
  logic [ert_pkg::EPOCH_W-1:0]     rd_epoch;
  logic                            rd_active;

  logic [ert_pkg::CNT_CMP_W-1:0]   core_ext, eff_cmp;
  logic [CW-1:0]                   eff_count;
  logic                            cpu_bad;
  logic                            age_ok;
  logic                            issuing;

  // effective processor count
  assign core_ext  = {2'b00, ncores_r};
  assign eff_cmp   = (core_ext < ert_pkg::CNT_CMP_W'(MAX_CPUS)) ?
                     core_ext : ert_pkg::CNT_CMP_W'(MAX_CPUS);
  assign eff_count = CW'(eff_cmp);
  assign cpu_bad   = ({3'b000, cpu_r} >= eff_cmp);
  assign issuing   = (issue_r < eff_count);

  // age check on global - death
  assign age_ok = (|sub_diff[ert_pkg::EPOCH_W-1:ert_pkg::THRESH_W]) ||
                  (sub_diff[ert_pkg::THRESH_W-1:0] >= thresh_r);

  ert_sub_unit u_sub (
    .op_a   (sub_a),
    .op_b   (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  ert_epoch_store #(
    .MAX_CPUS (MAX_CPUS),
    .AW       (AW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (st_ctl),
    .wr_addr   (AW'(cpu_r)),
    .wr_data   (global_r),
    .rd_addr   (issue_r[AW-1:0]),
    .rd_epoch  (rd_epoch),
    .rd_active (rd_active)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncores_r <= ert_pkg::CORE_CNT_RESET;
      thresh_r <= ert_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        ert_pkg::CFG_CORE_COUNT:      ncores_r <= cfg_wdata[ert_pkg::CORE_CNT_W-1:0];
        ert_pkg::CFG_EPOCH_THRESHOLD: thresh_r <= cfg_wdata[ert_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ert_pkg::ST_IDLE;
      global_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      global_r    <= global_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    cpu_r       <= cpu_nxt;
    death_r     <= death_nxt;
    issue_r     <= issue_nxt;
    out_safe_r  <= out_safe_nxt;
    out_epoch_r <= out_epoch_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    cpu_nxt       = cpu_r;
    death_nxt     = death_r;
    global_nxt    = global_r;
    issue_nxt     = issue_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = 1'b0;
    out_safe_nxt  = out_safe_r;
    out_epoch_nxt = out_epoch_r;
    out_rej_nxt   = out_rej_r;
    st_ctl        = '0;
    sub_a         = global_r;
    sub_b         = death_r;
    case (state_r)
      ert_pkg::ST_IDLE: begin
        if (start) begin
          func_nxt  = ert_pkg::func_t'(in_func);
          cpu_nxt   = in_cpu_index;
          death_nxt = in_death_epoch;
          state_nxt = ert_pkg::ST_EXEC;
        end
      end
      ert_pkg::ST_EXEC: begin
        out_safe_nxt  = 1'b0;
        out_rej_nxt   = 1'b0;
        out_epoch_nxt = global_r;
        case (func_r)
          ert_pkg::FUNC_ENTER, ert_pkg::FUNC_EXIT: begin
            if (cpu_bad) begin
              out_rej_nxt = 1'b1;
            end else begin
              st_ctl.flag_wr  = 1'b1;
              st_ctl.flag_val = (func_r == ert_pkg::FUNC_ENTER);
              st_ctl.epoch_wr = (func_r == ert_pkg::FUNC_ENTER);
            end
            out_valid_nxt = 1'b1;
            state_nxt     = ert_pkg::ST_IDLE;
          end
          ert_pkg::FUNC_ADVANCE: begin
            // global - all ones is global + 1 modulo 2^64
            sub_b         = '1;
            global_nxt    = sub_diff;
            out_epoch_nxt = sub_diff;
            out_valid_nxt = 1'b1;
            state_nxt     = ert_pkg::ST_IDLE;
          end
          ert_pkg::FUNC_QUERY: begin
            if (!age_ok) begin
              out_valid_nxt = 1'b1;
              state_nxt     = ert_pkg::ST_IDLE;
            end else if (eff_count == '0) begin
              out_safe_nxt  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = ert_pkg::ST_IDLE;
            end else begin
              issue_nxt = '0;
              state_nxt = ert_pkg::ST_SCAN;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = ert_pkg::ST_IDLE;
          end
        endcase
      end
      ert_pkg::ST_SCAN: begin
        // read one entry per cycle while entries remain, check the previous read: local <= death
        sub_a = death_r;
        sub_b = rd_epoch;
        if (issuing) begin
          st_ctl.rd_en = 1'b1;
          issue_nxt    = issue_r + CW'(1);
          pend_nxt     = 1'b1;
        end
        if (pend_r && rd_active && !sub_borrow) begin
          out_safe_nxt  = 1'b0;
          out_valid_nxt = 1'b1;
          state_nxt     = ert_pkg::ST_IDLE;
        end else if (!issuing) begin
          out_safe_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ert_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ert_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy                = (state_r != ert_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_safe_to_reclaim = out_safe_r;
  assign out_epoch_value     = out_epoch_r;
  assign out_rejected        = out_rej_r;

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // one strobe per item, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // rejected only for enter or exit
  a_rej_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |->
      (func_r == ert_pkg::FUNC_ENTER || func_r == ert_pkg::FUNC_EXIT))
    else $error("rejected flagged for advance or query");

  // safe only for a query
  a_safe_func: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_safe_r) |-> (func_r == ert_pkg::FUNC_QUERY))
    else $error("safe flagged for a non-query item");

  // advance reports the incremented epoch
  a_advance_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && func_r == ert_pkg::FUNC_ADVANCE) |->
      (out_epoch_r == $past(global_r) + 64'd1))
    else $error("advance result is not the incremented epoch");

endmodule
